// ===== design/jsu_pkg.sv =====
// Package for the JSON string unescaper: item status codes, parser modes,
// the command record passed from front to back end, and queue sizing.
// No dependencies.
package jsu_pkg;

   typedef enum logic [1:0] {
      ST_DATA  = 2'd0,
      ST_ERROR = 2'd1,
      ST_END   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MODE_TEXT = 2'd0,
      MODE_ESC  = 2'd1,
      MODE_HEX  = 2'd2
   } mode_type;

   // Up to four result bytes for one accepted input item, first in data[0].
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [1:0]      last_idx;
   } utf8_type;

   typedef struct packed {
      logic [3:0][7:0] data;
      logic [1:0]      last_idx;
      status_type      status;
      logic            eom;
   } cmd_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_BACKSLASH = 8'h5c;
   localparam logic [7:0] CH_U         = 8'h75;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6e;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_T         = 8'h74;

   localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;
   localparam logic [5:0]  LOW_SURR_TAG  = 6'b110111;
   localparam logic [20:0] SUPPL_BASE    = 21'h10000;

endpackage

// ===== design/jsu_req_if.sv =====
// Input channel of the unescaper: one escaped byte per item with an
// end-of-message flag. Valid/ready handshake. No dependencies.
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_message;

   modport source (output valid, output in_byte, output end_of_message, input ready);
   modport sink (input valid, input in_byte, input end_of_message, output ready);
endinterface

// ===== design/jsu_rsp_if.sv =====
// Result channel of the unescaper: one decoded byte or status per item.
// Valid/ready handshake. No dependencies.
interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] status;
   logic       last_of_run;
   logic       message_done;

   modport source (output valid, output out_byte, output status, output last_of_run,
                   output message_done, input ready);
   modport sink (input valid, input out_byte, input status, input last_of_run,
                 input message_done, output ready);
endinterface

// ===== design/jsu_front.sv =====
// Front end: accepts escaped bytes, runs the escape/hex/surrogate parser and
// builds one command per item that yields results. Uses jsu_pkg, jsu_req_if.
module jsu_front (
   input  logic             clock,
   input  logic             reset,
   jsu_req_if.sink          req_if,
   input  logic             q_full,
   output logic             push,
   output jsu_pkg::cmd_type push_cmd
);
   import jsu_pkg::*;

   mode_type    mode_ff, mode_in;
   logic [1:0]  digits_ff, digits_in;
   logic [15:0] acc_ff, acc_in;
   logic        hs_valid_ff, hs_valid_in;
   logic [9:0]  hs_bits_ff, hs_bits_in;
   logic        discard_ff, discard_in;

   logic        fire;
   logic [7:0]  c;
   logic        eom;
   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [15:0] acc_next;
   logic        has_data;
   logic        err;
   utf8_type    enc;
   logic [20:0] pair_cp;

   function automatic utf8_type encode(input logic [20:0] cp);
      utf8_type r;
      r = '0;
      if (cp <= 21'h7f) begin
         r.data[0]  = cp[7:0];
         r.last_idx = 2'd0;
      end else if (cp <= 21'h7ff) begin
         r.data[0]  = {3'b110, cp[10:6]};
         r.data[1]  = {2'b10, cp[5:0]};
         r.last_idx = 2'd1;
      end else if (cp <= 21'hffff) begin
         r.data[0]  = {4'b1110, cp[15:12]};
         r.data[1]  = {2'b10, cp[11:6]};
         r.data[2]  = {2'b10, cp[5:0]};
         r.last_idx = 2'd2;
      end else begin
         r.data[0]  = {5'b11110, cp[20:18]};
         r.data[1]  = {2'b10, cp[17:12]};
         r.data[2]  = {2'b10, cp[11:6]};
         r.data[3]  = {2'b10, cp[5:0]};
         r.last_idx = 2'd3;
      end
      return r;
   endfunction

   assign req_if.ready = !q_full;
   assign fire         = req_if.valid && !q_full;
   assign c            = req_if.in_byte;
   assign eom          = req_if.end_of_message;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         hex_val = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         hex_val = c[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign acc_next = {acc_ff[11:0], hex_val};
   assign pair_cp  = {1'b0, hs_bits_ff, acc_next[9:0]} + SUPPL_BASE;

   always_comb begin
      mode_in     = mode_ff;
      digits_in   = digits_ff;
      acc_in      = acc_ff;
      hs_valid_in = hs_valid_ff;
      hs_bits_in  = hs_bits_ff;
      discard_in  = discard_ff;
      has_data    = 1'b0;
      err         = 1'b0;
      enc         = '0;

      if (!discard_ff) begin
         case (mode_ff)
            MODE_ESC: begin
               mode_in = MODE_TEXT;
               if (c == CH_U) begin
                  mode_in   = MODE_HEX;
                  digits_in = 2'd0;
                  acc_in    = 16'd0;
                  err       = eom;
               end else begin
                  case (c)
                     CH_B:    enc.data[0] = 8'h08;
                     CH_F:    enc.data[0] = 8'h0c;
                     CH_N:    enc.data[0] = 8'h0a;
                     CH_R:    enc.data[0] = 8'h0d;
                     CH_T:    enc.data[0] = 8'h09;
                     default: enc.data[0] = c;
                  endcase
                  hs_valid_in = 1'b0;
                  has_data    = 1'b1;
               end
            end
            MODE_HEX: begin
               if (!hex_ok) begin
                  err = 1'b1;
               end else if (digits_ff != 2'd3) begin
                  acc_in    = acc_next;
                  digits_in = digits_ff + 2'd1;
                  err       = eom;
               end else begin
                  mode_in   = MODE_TEXT;
                  digits_in = 2'd0;
                  acc_in    = 16'd0;
                  if (acc_next[15:10] == HIGH_SURR_TAG) begin
                     hs_bits_in  = acc_next[9:0];
                     hs_valid_in = 1'b1;
                  end else if (acc_next[15:10] == LOW_SURR_TAG) begin
                     if (hs_valid_ff) begin
                        hs_valid_in = 1'b0;
                        enc         = encode(pair_cp);
                        has_data    = 1'b1;
                     end
                  end else begin
                     hs_valid_in = 1'b0;
                     enc         = encode({5'd0, acc_next});
                     has_data    = 1'b1;
                  end
               end
            end
            default: begin
               if (c == CH_BACKSLASH) begin
                  mode_in = MODE_ESC;
                  err     = eom;
               end else begin
                  hs_valid_in = 1'b0;
                  enc.data[0] = c;
                  has_data    = 1'b1;
               end
            end
         endcase
      end

      if (err) begin
         discard_in = 1'b1;
      end
      if (eom) begin
         mode_in     = MODE_TEXT;
         digits_in   = 2'd0;
         acc_in      = 16'd0;
         hs_valid_in = 1'b0;
         hs_bits_in  = 10'd0;
         discard_in  = 1'b0;
      end

      push_cmd.eom = eom;
      if (err) begin
         push_cmd.data     = '0;
         push_cmd.last_idx = 2'd0;
         push_cmd.status   = ST_ERROR;
      end else if (has_data) begin
         push_cmd.data     = enc.data;
         push_cmd.last_idx = enc.last_idx;
         push_cmd.status   = ST_DATA;
      end else begin
         push_cmd.data     = '0;
         push_cmd.last_idx = 2'd0;
         push_cmd.status   = ST_END;
      end
      push = fire && (err || has_data || eom);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_TEXT;
         digits_ff   <= 2'd0;
         acc_ff      <= 16'd0;
         hs_valid_ff <= 1'b0;
         hs_bits_ff  <= 10'd0;
         discard_ff  <= 1'b0;
      end else if (fire) begin
         mode_ff     <= mode_in;
         digits_ff   <= digits_in;
         acc_ff      <= acc_in;
         hs_valid_ff <= hs_valid_in;
         hs_bits_ff  <= hs_bits_in;
         discard_ff  <= discard_in;
      end
   end

endmodule

// ===== design/jsu_queue.sv =====
// Command queue between front and back end of the unescaper.
// Small register FIFO. Uses jsu_pkg.
module jsu_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsu_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output jsu_pkg::cmd_type head_cmd
);
   import jsu_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/jsu_back.sv =====
// Back end: walks the head command byte by byte onto the result channel and
// marks run and message ends. Uses jsu_pkg, jsu_rsp_if.
module jsu_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  jsu_pkg::cmd_type head_cmd,
   output logic             pop,
   jsu_rsp_if.source        rsp_if
);
   import jsu_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       last;
   logic       fire;

   assign last = (idx_ff == head_cmd.last_idx);
   assign fire = head_valid && rsp_if.ready;
   assign pop  = fire && last;

   assign rsp_if.valid        = head_valid;
   assign rsp_if.out_byte     = head_cmd.data[idx_ff];
   assign rsp_if.status       = head_cmd.status;
   assign rsp_if.last_of_run  = last;
   assign rsp_if.message_done = last && head_cmd.eom;

   always_comb begin
      idx_in = idx_ff;
      if (fire) begin
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// ===== design/json_string_unescaper_unit.sv =====
// JSON string unescaper: one escaped byte in per cycle, UTF-8 bytes out one
// per cycle while the output is ready. The front end parses and takes a byte
// every cycle while the 4-entry command queue has room; each byte yields 0 to
// 4 results, which the back end sends in turn from the registered queue, so
// throughput is set by the result count. Uses jsu_pkg and interfaces.
module json_string_unescaper_unit (
   input  logic        clock,
   input  logic        reset,
   jsu_req_if.sink     req_if,
   jsu_rsp_if.source   rsp_if
);
   import jsu_pkg::*;

   logic    push;
   cmd_type push_cmd;
   logic    q_full;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   jsu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .q_full   (q_full),
      .push     (push),
      .push_cmd (push_cmd)
   );

   jsu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule

// ===== tb/jsu_unescape_checker.sv =====
// Result checker for the JSON string unescaper: predicts the UTF-8 bytes,
// status and end flags of each accepted input item and compares the results.
// Depends on jsu_pkg, jsu_req_if and jsu_rsp_if.
module jsu_unescape_checker
   import jsu_pkg::*;
(
   input  logic clock,
   input  logic reset,
   jsu_req_if   req_mon,
   jsu_rsp_if   rsp_mon,
   output int   error_count,
   output int   backlog
);

   typedef struct {
      logic [7:0] out_byte;
      status_type status;
      logic       last_of_run;
      logic       message_done;
   } unescaped_t;

   unescaped_t expected_bytes[$];
   int         mismatches = 0;

   mode_type   mode;
   logic [1:0] digits;
   logic [15:0] acc;
   logic       hs_valid;
   logic [9:0] hs_bits;
   logic       discarding;

   assign error_count = mismatches;

   function automatic void clear_parser();
      mode       = MODE_TEXT;
      digits     = 2'd0;
      acc        = 16'd0;
      hs_valid   = 1'b0;
      hs_bits    = 10'd0;
      discarding = 1'b0;
   endfunction

   function automatic void predict_results(input logic [7:0] c, input logic eom);
      logic [7:0]  seq [4];
      int          n;
      int          v;
      logic        err;
      logic        have_cp;
      logic [20:0] cp;
      status_type  st;
      unescaped_t  r;
      n       = 0;
      err     = 1'b0;
      have_cp = 1'b0;
      cp      = 21'd0;
      st      = ST_DATA;
      if (discarding) begin
      end else if (mode == MODE_ESC) begin
         mode = MODE_TEXT;
         if (c == CH_U) begin
            mode   = MODE_HEX;
            digits = 2'd0;
            acc    = 16'd0;
            if (eom) err = 1'b1;
         end else begin
            case (c)
               CH_B:    seq[0] = 8'h08;
               CH_F:    seq[0] = 8'h0c;
               CH_N:    seq[0] = 8'h0a;
               CH_R:    seq[0] = 8'h0d;
               CH_T:    seq[0] = 8'h09;
               default: seq[0] = c;
            endcase
            hs_valid = 1'b0;
            n = 1;
         end
      end else if (mode == MODE_HEX) begin
         if (c >= "0" && c <= "9") v = c - "0";
         else if (c >= "a" && c <= "f") v = c - "a" + 10;
         else if (c >= "A" && c <= "F") v = c - "A" + 10;
         else v = -1;
         if (v < 0) begin
            err = 1'b1;
         end else begin
            acc = {acc[11:0], v[3:0]};
            if (digits != 2'd3) begin
               digits = digits + 2'd1;
               if (eom) err = 1'b1;
            end else begin
               mode   = MODE_TEXT;
               digits = 2'd0;
               if (acc[15:10] == HIGH_SURR_TAG) begin
                  hs_bits  = acc[9:0];
                  hs_valid = 1'b1;
               end else if (acc[15:10] == LOW_SURR_TAG) begin
                  // lone low surrogate gives nothing
                  if (hs_valid) begin
                     cp       = {hs_bits, acc[9:0]} + SUPPL_BASE;
                     hs_valid = 1'b0;
                     have_cp  = 1'b1;
                  end
               end else begin
                  cp       = {5'd0, acc};
                  hs_valid = 1'b0;
                  have_cp  = 1'b1;
               end
               acc = 16'd0;
            end
         end
      end else begin
         if (c == CH_BACKSLASH) begin
            mode = MODE_ESC;
            if (eom) err = 1'b1;
         end else begin
            hs_valid = 1'b0;
            seq[0]   = c;
            n        = 1;
         end
      end

      if (have_cp) begin
         if (cp <= 21'h7f) begin
            seq[0] = cp[7:0];
            n = 1;
         end else if (cp <= 21'h7ff) begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
            n = 2;
         end else if (cp <= 21'hffff) begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
            n = 3;
         end else begin
            seq[0] = {5'b11110, cp[20:18]};
            seq[1] = {2'b10, cp[17:12]};
            seq[2] = {2'b10, cp[11:6]};
            seq[3] = {2'b10, cp[5:0]};
            n = 4;
         end
      end

      if (err) begin
         seq[0]     = 8'h00;
         st         = ST_ERROR;
         n          = 1;
         discarding = 1'b1;
      end else if (n == 0 && eom) begin
         seq[0] = 8'h00;
         st     = ST_END;
         n      = 1;
      end

      for (int i = 0; i < n; i++) begin
         r.out_byte     = seq[i];
         r.status       = st;
         r.last_of_run  = (i == n - 1);
         r.message_done = (i == n - 1) && eom;
         expected_bytes.push_back(r);
      end
      if (eom) clear_parser();
   endfunction

   always @(posedge clock) begin
      unescaped_t want;
      if (reset) begin
         clear_parser();
         expected_bytes.delete();
         backlog <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_bytes.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected item, actual byte %h status %0d last %b done %b",
                        $time, rsp_mon.out_byte, rsp_mon.status, rsp_mon.last_of_run,
                        rsp_mon.message_done);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_mon.out_byte !== want.out_byte || rsp_mon.status !== want.status ||
                   rsp_mon.last_of_run !== want.last_of_run ||
                   rsp_mon.message_done !== want.message_done) begin
                  mismatches++;
                  $display("%0t: expected byte %h status %0d last %b done %b, actual %h %0d %b %b",
                           $time, want.out_byte, want.status, want.last_of_run,
                           want.message_done, rsp_mon.out_byte, rsp_mon.status,
                           rsp_mon.last_of_run, rsp_mon.message_done);
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            predict_results(req_mon.in_byte, req_mon.end_of_message);
         backlog <= expected_bytes.size();
      end
   end

endmodule

// ===== tb/tb_json_string_unescaper_unit.sv =====
// Testbench top for json_string_unescaper_unit: drives directed and random
// escaped messages with random idling on both channels and gives the verdict.
// Depends on jsu_pkg, the channel interfaces and jsu_unescape_checker.
module tb_json_string_unescaper_unit;
   import jsu_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 24;
   localparam int ITEM_TARGET  = 370;
   localparam int CALM_FROM    = 330;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   int         cycle_count = 0;
   logic       allow_idle = 1'b1;
   int         items_sent = 0;
   int         error_count;
   int         backlog;
   logic [7:0] msg_bytes[$];

   jsu_req_if req_bus ();
   jsu_rsp_if rsp_bus ();

   json_string_unescaper_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   jsu_unescape_checker unescape_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .error_count (error_count),
      .backlog     (backlog)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb_json_string_unescaper_unit: errors");
      $finish;
   end

   initial rsp_bus.ready <= 1'b0;

   always begin
      @(posedge clock);
      if (allow_idle && !reset && $urandom_range(0, 5) == 0) begin
         rsp_bus.ready <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      rsp_bus.ready <= 1'b1;
   end

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) return "0" + nib;
      return ($urandom_range(0, 1) ? "a" : "A") + nib - 8'd10;
   endfunction

   function automatic void push_code(input logic [15:0] u);
      msg_bytes.push_back(CH_BACKSLASH);
      msg_bytes.push_back(CH_U);
      for (int i = 3; i >= 0; i--) msg_bytes.push_back(hex_char(u[i*4 +: 4]));
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic eom);
      if (allow_idle && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.in_byte        <= b;
      req_bus.end_of_message <= eom;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_msg();
      allow_idle = (items_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
      foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
      msg_bytes.delete();
   endtask

   function automatic void add_token();
      logic [7:0]  b;
      logic [15:0] u;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_BACKSLASH);
            msg_bytes.push_back(b);
         end
         3, 4: begin
            msg_bytes.push_back(CH_BACKSLASH);
            case ($urandom_range(0, 5))
               0: b = CH_B;
               1: b = CH_F;
               2: b = CH_N;
               3: b = CH_R;
               4: b = CH_T;
               default: do b = 8'($urandom_range(0, 255)); while (b == CH_U);
            endcase
            msg_bytes.push_back(b);
         end
         5: push_code(16'($urandom_range(16'h0000, 16'h007f)));
         6: push_code(16'($urandom_range(16'h0080, 16'h07ff)));
         7: push_code(16'($urandom_range(16'h0800, 16'hffff)));
         8: begin
            push_code(16'($urandom_range(16'hd800, 16'hdbff)));
            push_code(16'($urandom_range(16'hdc00, 16'hdfff)));
         end
         default: begin
            u = 16'($urandom_range(16'hd800, 16'hdfff));
            push_code(u);
         end
      endcase
   endfunction

   function automatic void build_random_msg();
      int         kind;
      int         k;
      logic [7:0] b;
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
         repeat ($urandom_range(1, 6)) add_token();
      end else if (kind == 8) begin
         // bad hex digit, then noise that gets discarded
         if ($urandom_range(0, 1)) add_token();
         msg_bytes.push_back(CH_BACKSLASH);
         msg_bytes.push_back(CH_U);
         k = $urandom_range(0, 3);
         repeat (k) msg_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
         do b = 8'($urandom_range(0, 255));
         while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"));
         msg_bytes.push_back(b);
         repeat ($urandom_range(0, 3)) msg_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         // message cut off inside an escape
         if ($urandom_range(0, 1)) add_token();
         msg_bytes.push_back(CH_BACKSLASH);
         if ($urandom_range(0, 2) != 0) begin
            msg_bytes.push_back(CH_U);
            k = $urandom_range(0, 3);
            repeat (k) msg_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
         end
      end
   endfunction

   initial begin
      req_bus.valid          <= 1'b0;
      req_bus.in_byte        <= 8'h00;
      req_bus.end_of_message <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // surrogate pair to a four-byte sequence
      push_code(16'hD83D);
      push_code(16'hde00);
      send_msg();
      // lone low surrogate, end marker only
      push_code(16'hDC00);
      send_msg();
      // bad hex digit, then a discarded byte
      msg_bytes = '{CH_BACKSLASH, CH_U, "0", "g", "x"};
      send_msg();
      // message ends right after a backslash
      msg_bytes = '{8'h00, CH_BACKSLASH};
      send_msg();
      msg_bytes = '{8'hff};
      send_msg();
      msg_bytes = '{CH_BACKSLASH, CH_N};
      send_msg();

      while (items_sent < ITEM_TARGET) begin
         build_random_msg();
         send_msg();
      end
      req_bus.valid <= 1'b0;

      do @(posedge clock); while (backlog != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && backlog == 0)
         $display("tb_json_string_unescaper_unit: clean");
      else
         $display("tb_json_string_unescaper_unit: errors");
      $finish;
   end

endmodule
